>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the sorted table search block.
// No dependencies; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition a implies condition c in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Condition a implies condition c in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)

`endif

`endif

>>> sv/stbs_pkg.sv
// Package for the sorted table search block: sizes and command codes.
// No dependencies.
`timescale 1ns / 1ps

package stbs_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int PTR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);

	localparam int ADDR_W  = 24;
	localparam int SLOT_W  = 12;
	localparam int INDEX_W = 12;
	localparam int COUNT_W = 13;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

endpackage

>>> sv/sorted_table_binary_search_unit.sv
// Top level of the sorted table search block: table RAM, search sequencer, result register.
// Depends on stbs_pkg, stbs_ram and assert_macros.svh.
`timescale 1ns / 1ps

// The block keeps a table of 24-bit code addresses in one synchronous RAM and answers
// lookups by binary search over the first entry_count slots (an entry_count above the
// table depth counts as the full table). A load request writes key_addr into slot and
// produces no result; a slot beyond the table is ignored. A lookup request produces
// exactly one result: found and the matching slot, or found 0 with index 0. Each
// probe has a RAM read step in SEARCH and a compare step in CMP, because the table
// sits behind a single read port with registered read data. A lookup also waits in
// FINISH until the result register is free. The block handles one request at a time,
// but a new request is accepted while the previous result still waits in the output
// register. The table has no reset: a lookup must only probe slots that have been
// loaded since reset. The user must write entry_count only while the block is idle;
// the block itself does not enforce it.

`include "assert_macros.svh"

module sorted_table_binary_search_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [stbs_pkg::COUNT_W-1:0]   cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [stbs_pkg::SLOT_W-1:0]    slot,
	input  logic [stbs_pkg::ADDR_W-1:0]    key_addr,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [stbs_pkg::INDEX_W-1:0]   match_index
);

	import stbs_pkg::*;

	// Search sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_CMP    = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q;

	logic [COUNT_W-1:0] entry_count_q;
	logic [ADDR_W-1:0]  key_q;
	logic [BOUND_W-1:0] lo_q;
	logic [BOUND_W-1:0] hi_q;
	logic [PTR_W-1:0]   mid_q;
	logic               res_found_q;
	logic [INDEX_W-1:0] res_index_q;
	logic               out_valid_q;
	logic               found_q;
	logic [INDEX_W-1:0] match_index_q;

	logic               in_fire;
	logic               load_we;
	logic               range_open;
	logic [BOUND_W-1:0] mid_calc;
	logic [BOUND_W-1:0] hi_init;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_rdata;
	logic               out_free;

	// Requests are taken only while the sequencer is idle; the result register is
	// separate, so a pending result does not block the next request.
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign load_we  = in_fire && (cmd == CMD_LOAD) && (32'(slot) < 32'(TABLE_DEPTH));

	// Probe position: midpoint of the open range, rounded down.
	assign range_open = (lo_q < hi_q);
	assign mid_calc   = lo_q + ((hi_q - lo_q) >> 1);
	assign ram_re     = (state_q == ST_SEARCH) && range_open;

	// Upper bound saturates at the table depth.
	assign hi_init = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ?
		BOUND_W'(TABLE_DEPTH) : BOUND_W'(entry_count_q);

	assign out_free = !out_valid_q || out_ready;

	stbs_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (load_we),
		.waddr (PTR_W'(slot)),
		.wdata (key_addr),
		.re    (ram_re),
		.raddr (PTR_W'(mid_calc)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	// Sequencer: SEARCH issues the RAM read at the midpoint, CMP narrows the range
	// with the returned entry, FINISH waits for the result register to be free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (cmd == CMD_LOOKUP)) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					state_q <= range_open ? ST_CMP : ST_FINISH;
				end
				ST_CMP: begin
					state_q <= (ram_rdata == key_q) ? ST_FINISH : ST_SEARCH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Search datapath; none of it needs a reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					key_q       <= key_addr;
					lo_q        <= '0;
					hi_q        <= hi_init;
					res_found_q <= 1'b0;
					res_index_q <= '0;
				end
			end
			ST_SEARCH: begin
				mid_q <= PTR_W'(mid_calc);
			end
			ST_CMP: begin
				if (ram_rdata == key_q) begin
					res_found_q <= 1'b1;
					res_index_q <= INDEX_W'(mid_q);
				end else if (ram_rdata < key_q) begin
					lo_q <= BOUND_W'(mid_q) + BOUND_W'(1);
				end else begin
					hi_q <= BOUND_W'(mid_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FINISH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			found_q       <= res_found_q;
			match_index_q <= res_index_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign match_index = match_index_q;

	// The search range never inverts.
	`ASSERT_IMPLIES(a_range_ordered, clk, arst_n, state_q == ST_SEARCH, lo_q <= hi_q)
	// The probe being compared lies inside the current range.
	`ASSERT_IMPLIES(a_probe_in_range, clk, arst_n, state_q == ST_CMP,
		(BOUND_W'(mid_q) >= lo_q) && (BOUND_W'(mid_q) < hi_q))
	// A miss always reports slot zero.
	`ASSERT_IMPLIES(a_miss_index_zero, clk, arst_n, out_valid_q && !found_q,
		match_index_q == '0)
	// A search that ends leaves a result waiting in the next cycle.
	`ASSERT_NEXT(a_finish_delivers, clk, arst_n, (state_q == ST_FINISH) && out_free,
		out_valid_q && (state_q == ST_IDLE))

endmodule

>>> sv/stbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module stbs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sim/sorted_table_binary_search_unit_tb.sv
// Self-checking testbench for sorted_table_binary_search_unit: directed and random
// load and lookup traffic, checked against a behavioral binary search over a shadow table.
// Depends on stbs_pkg and the RTL of the block.
`timescale 1ns / 1ps

module sorted_table_binary_search_unit_tb;

	import stbs_pkg::*;

	// A run needs far fewer cycles than this. The limit only catches a hung block.
	localparam int CYCLE_LIMIT   = 1_000_000;
	// This covers any request still in flight once the owed results are back.
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 350;
	// Slots loaded with an ascending base table before the random phases; random
	// lookups never search past them, so every probed slot has been written.
	localparam int FILL_SLOTS    = 128;
	localparam int HOLD_CYCLES   = 400;
	localparam int MAX_COUNT     = (1 << COUNT_W) - 1;
	localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] index;
	} lookup_result_t;

	// Ways the result side accepts results when it is not in a long hold-off.
	typedef enum int {
		READY_ALWAYS,
		READY_HALF,
		READY_SPARSE,
		READY_TOGGLE
	} ready_mode_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic               cmd       = CMD_LOAD;
	logic [SLOT_W-1:0]  slot      = '0;
	logic [ADDR_W-1:0]  key_addr  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               found;
	logic [INDEX_W-1:0] match_index;

	// Shadow copy of the table and of entry_count, kept in step with every accepted
	// request. Lookup results the block still owes wait in pending_lookups, oldest first.
	logic [ADDR_W-1:0]  shadow_table [TABLE_DEPTH];
	logic [COUNT_W-1:0] shadow_count = '0;
	lookup_result_t     pending_lookups [$];

	int error_count = 0;
	int cycle_count = 0;
	int burst_left  = 0;

	// Long hold-off handshake between the stimulus and the result side: the stimulus
	// bumps hold_asked, the result side notices and counts the hold-off itself.
	int          hold_asked = 0;
	int          hold_taken = 0;
	int          hold_left  = 0;
	int          mode_left  = 0;
	ready_mode_t ready_mode = READY_ALWAYS;

	sorted_table_binary_search_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.slot        (slot),
		.key_addr    (key_addr),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.match_index (match_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_table_binary_search_unit_tb failed");
			$finish;
		end
	end

	// Binary search with a low bound and an exclusive high bound, probing the
	// rounded-down midpoint. A count above the table depth means the whole table.
	// The first equal entry on the probe path wins, so duplicates and unsorted
	// contents give exactly the slot that this probe order reaches.
	function automatic lookup_result_t search_table(input logic [ADDR_W-1:0] key);
		int             lo;
		int             hi;
		int             mid;
		lookup_result_t res;
		lo  = 0;
		hi  = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
		res = '0;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (shadow_table[mid] == key) begin
				res.hit   = 1'b1;
				res.index = mid[INDEX_W-1:0];
				return res;
			end
			if (shadow_table[mid] < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		return res;
	endfunction

	// Result side: each accepted result is compared field by field with the
	// oldest lookup still owed. Sampling at the edge sees the values that were
	// settled before it, since every driver here and in the block uses the edge.
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_lookups.size() == 0) begin
				$display("%0t: result with no lookup pending, found %0b index %0d",
					$time, found, match_index);
				error_count++;
			end else begin
				want = pending_lookups.pop_front();
				if (found !== want.hit) begin
					$display("%0t: found mismatch, expected %0b, actual %0b",
						$time, want.hit, found);
					error_count++;
				end
				if (match_index !== want.index) begin
					$display("%0t: match_index mismatch, expected %0d, actual %0d",
						$time, want.index, match_index);
					error_count++;
				end
			end
		end
	end

	// Result side stall pattern. It switches between a few modes every so often,
	// one of which never stalls, and runs a long hold-off when asked so that the
	// block fills up and has to drop in_ready.
	always @(posedge clk) begin
		if (hold_asked != hold_taken) begin
			hold_taken = hold_asked;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(50, 250);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				READY_ALWAYS: out_ready <= 1'b1;
				READY_HALF:   out_ready <= 1'($urandom_range(0, 1));
				READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:      out_ready <= ~out_ready;
			endcase
		end
	end

	// Presents one request and holds it until the block takes it, then updates
	// the shadow state. in_valid is left high so that a following request can go
	// out back to back; the pacing and idle tasks lower it.
	task automatic send_request(input logic op, input logic [SLOT_W-1:0] where,
			input logic [ADDR_W-1:0] addr);
		in_valid <= 1'b1;
		cmd      <= op;
		slot     <= where;
		key_addr <= addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op == CMD_LOAD)
			shadow_table[where] = addr;
		else
			pending_lookups.push_back(search_table(addr));
	endtask

	task automatic go_idle(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Requests go out in bursts of random length with random gaps; now and then a
	// burst is long enough to give a stretch with no gaps at all.
	task automatic send_paced(input logic op, input logic [SLOT_W-1:0] where,
			input logic [ADDR_W-1:0] addr);
		send_request(op, where, addr);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			go_idle($urandom_range(1, 12));
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(0, 15);
		end
	endtask

	task automatic lookup(input logic [ADDR_W-1:0] addr);
		send_paced(CMD_LOOKUP, SLOT_W'($urandom), addr);
	endtask

	// Waits until every owed result has come back, then a little longer so that a
	// trailing load, which gives no result, is finished as well.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// entry_count is only written once the block has nothing in flight.
	task automatic write_entry_count(input int value);
		wait_for_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= COUNT_W'(value);
		@(posedge clk);
		cfg_we       <= 1'b0;
		shadow_count = COUNT_W'(value);
	endtask

	// Straight after reset entry_count is zero, so lookups must miss with index 0.
	task automatic test_empty_table();
		lookup('0);
		lookup(ADDR_MAX);
	endtask

	// Five sorted entries that include both address extremes: every entry is hit,
	// and keys between entries miss.
	task automatic test_sorted_table();
		send_paced(CMD_LOAD, 12'd0, 24'h000000);
		send_paced(CMD_LOAD, 12'd1, 24'h000123);
		send_paced(CMD_LOAD, 12'd2, 24'h7FFFFF);
		send_paced(CMD_LOAD, 12'd3, 24'h800000);
		send_paced(CMD_LOAD, 12'd4, ADDR_MAX);
		write_entry_count(5);
		lookup(24'h000000);
		lookup(ADDR_MAX);
		lookup(24'h7FFFFF);
		lookup(24'h800000);
		lookup(24'h000123);
		lookup(24'h000124);
		lookup(24'h000001);
	endtask

	// Two equal neighbors: the hit slot depends on which one the probes reach first,
	// and that changes with entry_count.
	task automatic test_duplicate_keys();
		send_paced(CMD_LOAD, 12'd1, 24'h7FFFFF);
		lookup(24'h7FFFFF);
		write_entry_count(2);
		lookup(24'h7FFFFF);
	endtask

	// A descending table: the search follows its probes and misses keys that are there.
	task automatic test_unsorted_table();
		send_paced(CMD_LOAD, 12'd0, ADDR_MAX);
		send_paced(CMD_LOAD, 12'd2, 24'h000000);
		write_entry_count(3);
		lookup(ADDR_MAX);
		lookup(24'h000000);
		lookup(24'h7FFFFF);
	endtask

	// With the full table, or a count beyond it, the first probe lands on the middle
	// slot, so a key stored only there is safe to look up before the table is filled.
	task automatic test_count_beyond_table();
		send_paced(CMD_LOAD, 12'd2048, 24'hABCDEF);
		write_entry_count(TABLE_DEPTH);
		lookup(24'hABCDEF);
		write_entry_count(MAX_COUNT);
		lookup(24'hABCDEF);
	endtask

	// Fills the low FILL_SLOTS slots in ascending order up to the top address, then
	// runs phases: a new entry_count no larger than that, often a fresh sorted region
	// below it that stays under the entry above so the table stays ordered, and a run
	// of lookups mostly for keys that are present, with a few stray loads mixed in.
	task automatic test_random_traffic();
		int                count;
		int                span;
		int                sent;
		int                pick;
		int                step_max;
		int                value;
		logic [ADDR_W-1:0] key;
		value = 0;
		for (int s = 0; s < FILL_SLOTS; s++) begin
			if (s == FILL_SLOTS - 1)
				value = ADDR_MAX;
			send_paced(CMD_LOAD, SLOT_W'(s), ADDR_W'(value));
			value += $urandom_range(1, 4000);
		end
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 13)
				count = $urandom_range(1, 32);
			else if (pick < 17)
				count = $urandom_range(33, FILL_SLOTS - 1);
			else if (pick < 19)
				count = FILL_SLOTS;
			else
				count = 0;
			write_entry_count(count);
			span = count;
			if (count < FILL_SLOTS && $urandom_range(0, 3) != 0) begin
				step_max = int'(shadow_table[count]) / (count + 1);
				value    = $urandom_range(0, step_max);
				for (int s = 0; s < count; s++) begin
					send_paced(CMD_LOAD, SLOT_W'(s), ADDR_W'(value));
					// Step zero now and then puts equal keys side by side.
					if ($urandom_range(0, 7) != 0)
						value += $urandom_range(0, step_max);
					sent++;
				end
			end
			repeat ($urandom_range(4, 24)) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					send_paced(CMD_LOAD, SLOT_W'($urandom), ADDR_W'($urandom));
				end else begin
					if (span > 0 && pick < 12)
						key = shadow_table[$urandom_range(0, span - 1)];
					else if (span > 0 && pick < 15)
						key = shadow_table[$urandom_range(0, span - 1)]
							+ (($urandom_range(0, 1) == 0) ? 24'd1 : ADDR_MAX);
					else
						key = ADDR_W'($urandom);
					lookup(key);
				end
				sent++;
			end
		end
	endtask

	// The result side holds off for a long stretch while lookups keep coming back
	// to back, so the block fills up and has to hold off its input side too.
	task automatic test_output_backpressure();
		write_entry_count(FILL_SLOTS);
		hold_asked++;
		repeat (24)
			send_request(CMD_LOOKUP, SLOT_W'($urandom),
				shadow_table[$urandom_range(0, FILL_SLOTS - 1)]);
		wait_for_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_sorted_table();
		test_duplicate_keys();
		test_unsorted_table();
		test_count_beyond_table();
		test_random_traffic();
		test_output_backpressure();
		wait_for_idle();
		if (error_count == 0)
			$display("sorted_table_binary_search_unit_tb passed");
		else
			$display("sorted_table_binary_search_unit_tb failed");
		$finish;
	end

endmodule
